FILE: design/linear_interp_resampler_unit_macros.svh
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit_macros.svh
// Assertion macros shared by the resampler RTL. The including module must
// have i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LIRS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LIRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared constants and types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int MAX_UPSAMPLE     = 16;
    localparam int MAX_DOWNSAMPLE   = 64;
    localparam int MAX_RESULTS      = 32;
    localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam int RATE_W           = 18;
    localparam int DIVN_W           = RATE_W + 1;   // rem + rate fits here
    localparam int INPUT_RATE_RST   = 48000;
    localparam int OUTPUT_RATE_RST  = 16000;

    localparam int QUEUE_DEPTH      = 2;

    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_LSB      = 2;

    typedef enum logic {
        REG_INPUT_RATE  = 1'b0,
        REG_OUTPUT_RATE = 1'b1
    } t_reg_idx;

    // Request to the shared divider. weight=1: quotient of (part << WB) / d.
    // weight=0: quotient and remainder of num / d.
    typedef struct packed {
        logic                start;
        logic                weight;
        logic [DIVN_W-1:0]   num;
        logic [RATE_W-1:0]   part;
    } t_div_req;

endpackage

`default_nettype wire

FILE: design/lirs_fifo.sv
// ----------------------------------------------------------------------------
// lirs_fifo
// Small register queue, used for the command queue and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_fifo import lirs_pkg::*; #(
    parameter int WIDTH = SAMPLE_WIDTH_DEF + 2,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/lirs_front.sv
// ----------------------------------------------------------------------------
// lirs_front
// Input side: accepts sample beats, checks the rate ratio and queues a
// command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_front import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last,
    input  logic        [RATE_W-1:0]       i_input_rate,
    input  logic        [RATE_W-1:0]       i_output_rate,
    output logic                           o_cmd_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_cmd_sample,
    output logic                           o_cmd_last,
    output logic                           o_cmd_err,
    input  logic                           i_cmd_pop
);

    localparam int CMD_W   = SAMPLE_WIDTH + 2;
    localparam int SCALE_W = $clog2(MAX_DOWNSAMPLE * MAX_UPSAMPLE + 1);
    localparam int CMPW    = RATE_W + SCALE_W;

    logic [CMPW-1:0]  up_lim;
    logic [CMPW-1:0]  dn_lim;
    logic             ratio_err;
    logic [CMD_W-1:0] cmd_data;

    assign up_lim = CMPW'(i_input_rate) * CMPW'(MAX_UPSAMPLE);
    assign dn_lim = CMPW'(i_output_rate) * CMPW'(MAX_DOWNSAMPLE);

    assign ratio_err = (i_input_rate == '0) || (i_output_rate == '0) ||
                       (CMPW'(i_output_rate) > up_lim) ||
                       (CMPW'(i_input_rate) > dn_lim);

    lirs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({ratio_err, i_last, i_sample}),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_data),
        .o_valid (o_cmd_valid)
    );

    assign o_cmd_err    = cmd_data[CMD_W-1];
    assign o_cmd_last   = cmd_data[CMD_W-2];
    assign o_cmd_sample = cmd_data[SAMPLE_WIDTH-1:0];

endmodule

`default_nettype wire

FILE: design/lirs_div.sv
// ----------------------------------------------------------------------------
// lirs_div
// Restoring divider by the output rate, one quotient bit per cycle.
// Serves the phase advance, the remainder fold and the blend weight.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_div import lirs_pkg::*; #(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [RATE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [(WEIGHT_BITS > DIVN_W ? WEIGHT_BITS : DIVN_W)-1:0] o_quot,
    output logic [RATE_W-1:0] o_rem
);

    localparam int QW  = (WEIGHT_BITS > DIVN_W) ? WEIGHT_BITS : DIVN_W;
    localparam int STW = $clog2(QW + 1);

    logic              r_busy;
    logic              r_done;
    logic [STW-1:0]    r_cnt;
    logic [RATE_W-1:0] r_part;
    logic [QW-1:0]     r_x;
    logic [QW-1:0]     r_q;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              ge;

    // partial remainder stays below the divisor, so trial < 2*divisor
    assign trial = {r_part, r_x[QW-1]};
    assign ge    = (trial >= {1'b0, i_divisor});
    assign diff  = trial - {1'b0, i_divisor};

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == STW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == STW'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= '0;
            if (i_req.weight) begin
                r_part <= i_req.part;
                r_x    <= '0;
                r_cnt  <= STW'(WEIGHT_BITS);
            end else begin
                r_part <= '0;
                r_x    <= QW'(i_req.num) << (QW - DIVN_W);
                r_cnt  <= STW'(DIVN_W);
            end
        end else if (r_busy) begin
            r_part <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            r_x    <= r_x << 1;
            r_q    <= {r_q[QW-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: design/lirs_back.sv
// ----------------------------------------------------------------------------
// lirs_back
// Execution side: walks the output positions that fall on each input,
// blends neighbors and pushes results, marking the last of an utterance.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_back import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic        [RATE_W-1:0]       i_input_rate,
    input  logic        [RATE_W-1:0]       i_output_rate,
    input  logic                           i_cmd_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cmd_sample,
    input  logic                           i_cmd_last,
    input  logic                           i_cmd_err,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output logic signed [SAMPLE_WIDTH-1:0] o_res_sample,
    output logic                           o_res_last,
    output logic                           o_res_err
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int WB = WEIGHT_BITS;
    localparam int QW = (WB > DIVN_W) ? WB : DIVN_W;
    localparam int PW = SW + WB + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (WB - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FOLD  = 9'b000000010,
        ST_LOOP  = 9'b000000100,
        ST_WDIV  = 9'b000001000,
        ST_BLEND = 9'b000010000,
        ST_PUT   = 9'b000100000,
        ST_ADV   = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_ERR   = 9'b100000000
    } t_back_state;

    t_back_state           r_state, n_state;
    logic                  r_have, n_have;
    logic [31:0]           r_cnt, n_cnt;
    logic [31:0]           r_nidx, n_nidx;
    logic [RATE_W-1:0]     r_rem, n_rem;
    logic                  r_pend_valid, n_pend_valid;
    logic [RES_CNT_W-1:0]  r_n, n_n;

    logic signed [SW-1:0]  r_s, n_s;
    logic                  r_last, n_last;
    logic signed [SW-1:0]  r_prev, n_prev;
    logic signed [SW-1:0]  r_res, n_res;
    logic signed [SW-1:0]  r_pend, n_pend;
    logic signed [PW-1:0]  r_prod, n_prod;

    t_div_req              div_req;
    logic                  div_done;
    logic [QW-1:0]         div_quot;
    logic [RATE_W-1:0]     div_rem;

    logic [DIVN_W-1:0]     sum_ri;
    logic                  cap_ok;
    logic                  cond_a;
    logic                  cond_b;
    logic signed [SW:0]    diff;
    logic signed [WB:0]    w_s;
    logic signed [PW-1:0]  rnd;
    logic signed [PW-1:0]  sh;
    logic [SW:0]           blend_sum;

    lirs_div #(
        .WEIGHT_BITS (WB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (i_output_rate),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    assign sum_ri = {1'b0, r_rem} + {1'b0, i_input_rate};
    assign cap_ok = (r_n < RES_CNT_W'(MAX_RESULTS));

    // output between previous and current input
    assign cond_a = r_have && (r_nidx == (r_cnt - 32'd1)) &&
                    !(r_last && (sum_ri > {i_output_rate, 1'b0}));
    // output on the last input itself, only while it is still in range
    assign cond_b = r_last && (r_nidx == r_cnt) &&
                    !(sum_ri > {1'b0, i_output_rate});

    // a + round((b - a) * w / 2^WB)
    assign diff      = $signed({r_s[SW-1], r_s}) - $signed({r_prev[SW-1], r_prev});
    assign w_s       = $signed({1'b0, div_quot[WB-1:0]});
    assign rnd       = r_prod + HALF;
    assign sh        = rnd >>> WB;
    assign blend_sum = {r_prev[SW-1], r_prev} + sh[SW:0];

    always_comb begin
        n_state      = r_state;
        n_have       = r_have;
        n_cnt        = r_cnt;
        n_nidx       = r_nidx;
        n_rem        = r_rem;
        n_pend_valid = r_pend_valid;
        n_n          = r_n;
        n_s          = r_s;
        n_last       = r_last;
        n_prev       = r_prev;
        n_res        = r_res;
        n_pend       = r_pend;
        n_prod       = r_prod;
        div_req      = '0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res_sample = r_pend;
        o_res_last   = 1'b0;
        o_res_err    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_s       = i_cmd_sample;
                    n_last    = i_cmd_last;
                    n_n       = '0;
                    if (i_cmd_err) begin
                        n_state = ST_ERR;
                    end else if (r_rem >= i_output_rate) begin
                        // rates changed since the last beat
                        div_req.start  = 1'b1;
                        div_req.weight = 1'b0;
                        div_req.num    = {1'b0, r_rem};
                        n_state        = ST_FOLD;
                    end else begin
                        n_state = ST_LOOP;
                    end
                end
            end
            ST_FOLD: begin
                if (div_done) begin
                    n_nidx  = r_nidx + 32'(div_quot[DIVN_W-1:0]);
                    n_rem   = div_rem;
                    n_state = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (cap_ok && cond_a) begin
                    div_req.start  = 1'b1;
                    div_req.weight = 1'b1;
                    div_req.part   = r_rem;
                    n_state        = ST_WDIV;
                end else if (cap_ok && cond_b) begin
                    n_res   = r_s;
                    n_state = ST_PUT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WDIV: begin
                if (div_done) begin
                    n_prod  = diff * w_s;
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                n_res   = blend_sum[SW-1:0];
                n_state = ST_PUT;
            end
            ST_PUT: begin
                // hold the newest result back until we know if it is the final one
                if (!r_pend_valid || !i_res_full) begin
                    o_res_push     = r_pend_valid;
                    n_pend         = r_res;
                    n_pend_valid   = 1'b1;
                    n_n            = r_n + 1'b1;
                    div_req.start  = 1'b1;
                    div_req.weight = 1'b0;
                    div_req.num    = sum_ri;
                    n_state        = ST_ADV;
                end
            end
            ST_ADV: begin
                if (div_done) begin
                    n_nidx  = r_nidx + 32'(div_quot[DIVN_W-1:0]);
                    n_rem   = div_rem;
                    n_state = ST_LOOP;
                end
            end
            ST_DONE: begin
                if (!r_pend_valid || !i_res_full) begin
                    o_res_push   = r_pend_valid;
                    o_res_last   = r_last;
                    n_pend_valid = 1'b0;
                    if (r_last) begin
                        n_have = 1'b0;
                        n_cnt  = '0;
                        n_nidx = '0;
                        n_rem  = '0;
                    end else begin
                        n_prev = r_s;
                        n_have = 1'b1;
                        n_cnt  = r_cnt + 32'd1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res_sample = r_s;
                    o_res_last   = r_last;
                    o_res_err    = 1'b1;
                    n_have       = 1'b0;
                    n_cnt        = '0;
                    n_nidx       = '0;
                    n_rem        = '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_have       <= 1'b0;
            r_cnt        <= '0;
            r_nidx       <= '0;
            r_rem        <= '0;
            r_pend_valid <= 1'b0;
            r_n          <= '0;
        end else begin
            r_state      <= n_state;
            r_have       <= n_have;
            r_cnt        <= n_cnt;
            r_nidx       <= n_nidx;
            r_rem        <= n_rem;
            r_pend_valid <= n_pend_valid;
            r_n          <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_last <= n_last;
        r_prev <= n_prev;
        r_res  <= n_res;
        r_pend <= n_pend;
        r_prod <= n_prod;
    end

endmodule

`default_nettype wire

FILE: design/linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Streaming linear-interpolation sample rate converter for one utterance of
// signed mono samples, with an APB register port for the two rates.
// ----------------------------------------------------------------------------
// Samples go in through a push/full queue port and results come out through
// an empty/pop port; output i sits at input position i*input_rate/output_rate
// and blends its two neighbors by a truncated WEIGHT_BITS weight. The beat
// that carries last_in ends the utterance: its final result carries last_out
// and the phase state clears. With an unsupported ratio (a zero rate, more
// than 16x up or 64x down) each input comes straight back with ratio_error
// set. Every blended result takes a WEIGHT_BITS-step weight division and a
// 19-step phase-advance division, one quotient bit per cycle in the shared
// divider; every result that repeats the last sample takes the phase-advance
// division alone. A beat whose phase remainder no longer fits a new output
// rate adds one more division, and a full output queue stalls the back end.
// Two beats can wait ahead of the back end; behind it one result is held in
// the back end and two more in the output queue. Register 0 (address 0x0) is
// input_rate, register 1 (address 0x4) is output_rate, 18 bits each; write
// them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_interp_resampler_unit_macros.svh"

module linear_interp_resampler_unit import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_last_in,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_last_out,
    output logic                           o_ratio_error,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    output logic [APB_DATA_W-1:0]          prdata,
    output logic                           pready
);

    localparam int RES_W = SAMPLE_WIDTH + 2;

    logic [RATE_W-1:0]              r_input_rate;
    logic [RATE_W-1:0]              r_output_rate;
    logic                           cfg_wr;

    logic                           cmd_valid;
    logic signed [SAMPLE_WIDTH-1:0] cmd_sample;
    logic                           cmd_last;
    logic                           cmd_err;
    logic                           cmd_pop;

    logic                           res_push;
    logic                           res_full;
    logic signed [SAMPLE_WIDTH-1:0] res_sample;
    logic                           res_last;
    logic                           res_err;
    logic [RES_W-1:0]               res_data;
    logic                           res_valid;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rate  <= RATE_W'(INPUT_RATE_RST);
            r_output_rate <= RATE_W'(OUTPUT_RATE_RST);
        end else if (cfg_wr) begin
            unique case (paddr[REG_IDX_LSB])
                REG_INPUT_RATE:  r_input_rate  <= pwdata[RATE_W-1:0];
                REG_OUTPUT_RATE: r_output_rate <= pwdata[RATE_W-1:0];
                default:         r_input_rate  <= r_input_rate;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_IDX_LSB])
            REG_INPUT_RATE:  prdata = APB_DATA_W'(r_input_rate);
            REG_OUTPUT_RATE: prdata = APB_DATA_W'(r_output_rate);
            default:         prdata = '0;
        endcase
    end

    lirs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_sample      (i_sample_in),
        .i_last        (i_last_in),
        .i_input_rate  (r_input_rate),
        .i_output_rate (r_output_rate),
        .o_cmd_valid   (cmd_valid),
        .o_cmd_sample  (cmd_sample),
        .o_cmd_last    (cmd_last),
        .o_cmd_err     (cmd_err),
        .i_cmd_pop     (cmd_pop)
    );

    lirs_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_input_rate  (r_input_rate),
        .i_output_rate (r_output_rate),
        .i_cmd_valid   (cmd_valid),
        .i_cmd_sample  (cmd_sample),
        .i_cmd_last    (cmd_last),
        .i_cmd_err     (cmd_err),
        .o_cmd_pop     (cmd_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res_sample  (res_sample),
        .o_res_last    (res_last),
        .o_res_err     (res_err)
    );

    lirs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_err, res_last, res_sample}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_valid (res_valid)
    );

    assign empty         = !res_valid;
    assign o_ratio_error = res_data[RES_W-1];
    assign o_last_out    = res_data[RES_W-2];
    assign o_sample_out  = res_data[SAMPLE_WIDTH-1:0];

    `LIRS_ASSERT_HOLDS(a_res_no_overflow, res_push, !res_full, "result beat pushed while full")
    `LIRS_ASSERT_HOLDS(a_cmd_pop_valid, cmd_pop, cmd_valid, "command popped from empty queue")
    `LIRS_ASSERT_NEXT(a_pop_frees_slot, cmd_pop, !full, "input still full after command pop")

endmodule

`default_nettype wire
